FILE: rtl/core/crle_pkg.sv
// shared types, constants and helpers for the clipped line and fill raster engine
`default_nettype none

package crle_pkg;

   // screen geometry
   localparam int SCREEN_W = 320;
   localparam int SCREEN_H = 240;
   localparam int PIXELS   = SCREEN_W * SCREEN_H;
   localparam int AW       = $clog2(PIXELS);
   localparam int CW       = (SCREEN_W > SCREEN_H) ? $clog2(SCREEN_W) : $clog2(SCREEN_H);
   // signed working width for positions, ends and dash sums
   localparam int SPW      = 14;

   localparam logic [CW:0]          W_LIM    = (CW + 1)'(SCREEN_W);
   localparam logic [CW:0]          H_LIM    = (CW + 1)'(SCREEN_H);
   localparam logic signed [SPW-1:0] H_LAST  = SPW'(SCREEN_H - 1);
   localparam logic [AW-1:0]         ROW_STEP = AW'(SCREEN_W);

   typedef enum logic [2:0] {
      ACT_POINT  = 3'd0,
      ACT_HLINE  = 3'd1,
      ACT_VLINE  = 3'd2,
      ACT_DASH_H = 3'd3,
      ACT_DASH_V = 3'd4,
      ACT_FILL   = 3'd5,
      ACT_READ   = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SETUP,
      ST_ADDR,
      ST_RUN,
      ST_NEXT,
      ST_RDWAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         color;
      logic signed [11:0] x_a;
      logic signed [11:0] y_a;
      logic signed [11:0] x_b;
      logic signed [11:0] y_b;
      logic [10:0]        extent_w;
      logic [10:0]        extent_h;
      logic [7:0]         dash_on;
      logic [7:0]         dash_off;
      logic [8:0]         dash_phase;
   } req_type;

   typedef struct packed {
      logic [7:0] read_color;
      logic       bad_phase;
   } rsp_type;

   // widen a 12-bit coordinate to the working width
   function automatic logic signed [SPW-1:0] sext_f(input logic signed [11:0] v);
      sext_f = {{(SPW - 12){v[11]}}, v};
   endfunction

   // true when 0 <= v < lim
   function automatic logic in_range_f(input logic signed [SPW-1:0] v,
                                       input logic [CW:0] lim);
      logic signed [SPW-1:0] l;
      l = {{(SPW - CW - 1){1'b0}}, lim};
      in_range_f = (v >= 0) && (v < l);
   endfunction

   // clamp to 0 .. lim-1
   function automatic logic [CW-1:0] clamp_f(input logic signed [SPW-1:0] v,
                                             input logic [CW:0] lim);
      logic signed [SPW-1:0] l;
      logic [CW:0]           m;
      l = {{(SPW - CW - 1){1'b0}}, lim};
      m = lim - 1'b1;
      if (v < 0) begin
         clamp_f = '0;
      end else if (v >= l) begin
         clamp_f = m[CW-1:0];
      end else begin
         clamp_f = v[CW-1:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/crle_ram.sv
// generic single-port ram with registered read
`default_nettype none

module crle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/clipped_line_and_fill_raster_engine_core.sv
// top level: command sequencer, span walker and frame store
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | crle_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | crle_pkg::rsp_type
//   csr     | in        | csr_wr_en           | background color, 8 bits
//
// every command is reduced to clamped spans along one row or column; a single
// span walker writes one pixel per cycle through the frame store write port.
// req_stall is high from transfer until the result is loaded into the output
// register; the result register holds under rsp_stall.
// reset clears control state and the background register; the frame store
// holds no reset value and needs no clearing pass.
`default_nettype none

module clipped_line_and_fill_raster_engine_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire crle_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output crle_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data
);

   localparam int SPW = crle_pkg::SPW;
   localparam int CW  = crle_pkg::CW;
   localparam int AW  = crle_pkg::AW;

   crle_pkg::state_type state_ff, state_in, dec_next;
   crle_pkg::req_type   cmd_ff, cmd_in;
   crle_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          bg_ff, bg_in;
   logic [7:0]          rd_ff, rd_in;
   logic                bad_ff, bad_in;

   logic signed [SPW-1:0] pos_ff, pos_in;
   logic signed [SPW-1:0] end_ff, end_in;
   logic signed [SPW-1:0] row_ff, row_in;
   logic signed [SPW-1:0] sp_fix_ff, sp_fix_in;
   logic signed [SPW-1:0] sp_a_ff, sp_a_in;
   logic signed [SPW-1:0] sp_b_ff, sp_b_in;
   logic                  sp_horiz_ff, sp_horiz_in;
   logic [CW-1:0]         cur_ff, cur_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [CW-1:0]         fix_ff, fix_in;
   logic [AW-1:0]         addr_ff, addr_in;

   crle_pkg::action_type  act;
   logic signed [SPW-1:0] xa_s, ya_s, xb_s, yb_s;
   logic signed [SPW-1:0] dstart, dend, dfix, dpos0, open_b;
   logic signed [SPW-1:0] ya_h, fill_yr, fill_ye, dash_b;
   logic [8:0]            period;
   logic                  onscreen, phase_bad, fix_ok, last_px, load_rsp;
   logic [CW:0]           along_lim, fix_lim;
   logic [CW-1:0]         ca, cb, row_sel, col_sel;
   logic                  ram_we;
   logic [7:0]            ram_q;

   // frame store
   crle_ram #(
      .WIDTH (8),
      .DEPTH (crle_pkg::PIXELS)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (addr_ff),
      .wr_data (cmd_ff.color),
      .rd_data (ram_q)
   );

   // command fields at working width
   assign act     = crle_pkg::action_type'(cmd_ff.action);
   assign xa_s    = crle_pkg::sext_f(cmd_ff.x_a);
   assign ya_s    = crle_pkg::sext_f(cmd_ff.y_a);
   assign xb_s    = crle_pkg::sext_f(cmd_ff.x_b);
   assign yb_s    = crle_pkg::sext_f(cmd_ff.y_b);
   assign onscreen = crle_pkg::in_range_f(xa_s, crle_pkg::W_LIM) &&
                     crle_pkg::in_range_f(ya_s, crle_pkg::H_LIM);

   // dash pattern terms
   assign period    = {1'b0, cmd_ff.dash_on} + {1'b0, cmd_ff.dash_off};
   assign phase_bad = cmd_ff.dash_phase >= period;
   assign dstart    = (act == crle_pkg::ACT_DASH_H) ? xa_s : ya_s;
   assign dend      = (act == crle_pkg::ACT_DASH_H) ? xb_s : yb_s;
   assign dfix      = (act == crle_pkg::ACT_DASH_H) ? ya_s : xa_s;
   assign dpos0     = (cmd_ff.dash_phase != '0) ?
                      dstart + {{(SPW - 9){1'b0}}, period - cmd_ff.dash_phase} : dstart;
   assign open_b    = dstart + {{(SPW - 8){1'b0}}, cmd_ff.dash_on}
                      - {{(SPW - 9){1'b0}}, cmd_ff.dash_phase} - SPW'(1);
   assign dash_b    = pos_ff + {{(SPW - 8){1'b0}}, cmd_ff.dash_on} - SPW'(1);

   // fill row range, clipped to the screen
   assign ya_h    = ya_s + {{(SPW - 11){1'b0}}, cmd_ff.extent_h};
   assign fill_yr = (ya_s < 0) ? '0 : ya_s;
   assign fill_ye = (ya_h < crle_pkg::H_LAST) ? ya_h : crle_pkg::H_LAST;

   // span clamp
   assign along_lim = sp_horiz_ff ? crle_pkg::W_LIM : crle_pkg::H_LIM;
   assign fix_lim   = sp_horiz_ff ? crle_pkg::H_LIM : crle_pkg::W_LIM;
   assign fix_ok    = crle_pkg::in_range_f(sp_fix_ff, fix_lim);
   assign ca        = crle_pkg::clamp_f(sp_a_ff, along_lim);
   assign cb        = crle_pkg::clamp_f(sp_b_ff, along_lim);
   assign row_sel   = sp_horiz_ff ? fix_ff : cur_ff;
   assign col_sel   = sp_horiz_ff ? cur_ff : fix_ff;
   assign last_px   = cur_ff == hi_ff;
   assign load_rsp  = (state_ff == crle_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // decode: where a fresh command goes first
   always_comb begin
      case (act)
         crle_pkg::ACT_POINT, crle_pkg::ACT_READ:
            dec_next = onscreen ? crle_pkg::ST_SETUP : crle_pkg::ST_DONE;
         crle_pkg::ACT_HLINE, crle_pkg::ACT_VLINE:
            dec_next = crle_pkg::ST_SETUP;
         crle_pkg::ACT_DASH_H, crle_pkg::ACT_DASH_V: begin
            if (phase_bad || cmd_ff.dash_on == '0) begin
               dec_next = crle_pkg::ST_DONE;
            end else if (cmd_ff.dash_phase != '0 &&
                         {1'b0, cmd_ff.dash_phase} < {2'b0, cmd_ff.dash_on}) begin
               dec_next = crle_pkg::ST_SETUP;
            end else begin
               dec_next = crle_pkg::ST_NEXT;
            end
         end
         crle_pkg::ACT_FILL:
            dec_next = (cmd_ff.extent_w == '0 || cmd_ff.extent_h == '0 ||
                        fill_yr > fill_ye) ? crle_pkg::ST_DONE : crle_pkg::ST_SETUP;
         default:
            dec_next = crle_pkg::ST_DONE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crle_pkg::ST_IDLE:   if (req_valid) state_in = crle_pkg::ST_DECODE;
         crle_pkg::ST_DECODE: state_in = dec_next;
         crle_pkg::ST_SETUP:  state_in = fix_ok ? crle_pkg::ST_ADDR : crle_pkg::ST_NEXT;
         crle_pkg::ST_ADDR:   state_in = crle_pkg::ST_RUN;
         crle_pkg::ST_RUN: begin
            if (act == crle_pkg::ACT_READ) begin
               state_in = crle_pkg::ST_RDWAIT;
            end else if (last_px) begin
               state_in = crle_pkg::ST_NEXT;
            end
         end
         crle_pkg::ST_NEXT: begin
            if ((act == crle_pkg::ACT_DASH_H || act == crle_pkg::ACT_DASH_V) &&
                pos_ff < end_ff) begin
               state_in = crle_pkg::ST_SETUP;
            end else if (act == crle_pkg::ACT_FILL && row_ff < end_ff) begin
               state_in = crle_pkg::ST_SETUP;
            end else begin
               state_in = crle_pkg::ST_DONE;
            end
         end
         crle_pkg::ST_RDWAIT: state_in = crle_pkg::ST_DONE;
         crle_pkg::ST_DONE:   if (load_rsp) state_in = crle_pkg::ST_IDLE;
         default:             state_in = crle_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in      = cmd_ff;
      rsp_in      = rsp_ff;
      bg_in       = csr_wr_en ? csr_wr_data : bg_ff;
      rd_in       = rd_ff;
      bad_in      = bad_ff;
      pos_in      = pos_ff;
      end_in      = end_ff;
      row_in      = row_ff;
      sp_fix_in   = sp_fix_ff;
      sp_a_in     = sp_a_ff;
      sp_b_in     = sp_b_ff;
      sp_horiz_in = sp_horiz_ff;
      cur_in      = cur_ff;
      hi_in       = hi_ff;
      fix_in      = fix_ff;
      addr_in     = addr_ff;
      ram_we      = 1'b0;
      req_stall   = state_ff != crle_pkg::ST_IDLE;
      case (state_ff)
         // command transfer
         crle_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data;
               rd_in  = '0;
               bad_in = 1'b0;
            end
         end
         // first span of the command
         crle_pkg::ST_DECODE: begin
            case (act)
               crle_pkg::ACT_POINT, crle_pkg::ACT_READ, crle_pkg::ACT_HLINE: begin
                  sp_horiz_in = 1'b1;
                  sp_fix_in   = ya_s;
                  sp_a_in     = xa_s;
                  sp_b_in     = (act == crle_pkg::ACT_HLINE) ? xb_s : xa_s;
                  if (act == crle_pkg::ACT_READ && !onscreen) begin
                     rd_in = bg_ff;
                  end
               end
               crle_pkg::ACT_VLINE: begin
                  sp_horiz_in = 1'b0;
                  sp_fix_in   = xa_s;
                  sp_a_in     = ya_s;
                  sp_b_in     = yb_s;
               end
               crle_pkg::ACT_DASH_H, crle_pkg::ACT_DASH_V: begin
                  bad_in      = phase_bad;
                  sp_horiz_in = act == crle_pkg::ACT_DASH_H;
                  sp_fix_in   = dfix;
                  sp_a_in     = dstart;
                  sp_b_in     = open_b;
                  pos_in      = dpos0;
                  end_in      = dend;
               end
               crle_pkg::ACT_FILL: begin
                  sp_horiz_in = 1'b1;
                  sp_fix_in   = fill_yr;
                  sp_a_in     = xa_s;
                  sp_b_in     = xa_s + {{(SPW - 11){1'b0}}, cmd_ff.extent_w};
                  row_in      = fill_yr;
                  end_in      = fill_ye;
               end
               default: ;
            endcase
         end
         // clamp and order the span ends
         crle_pkg::ST_SETUP: begin
            cur_in = (ca < cb) ? ca : cb;
            hi_in  = (ca < cb) ? cb : ca;
            fix_in = sp_fix_ff[CW-1:0];
         end
         // linear address of the first pixel
         crle_pkg::ST_ADDR: begin
            addr_in = AW'(row_sel) * crle_pkg::ROW_STEP + AW'(col_sel);
         end
         // one pixel per cycle
         crle_pkg::ST_RUN: begin
            ram_we  = act != crle_pkg::ACT_READ;
            cur_in  = cur_ff + 1'b1;
            addr_in = sp_horiz_ff ? addr_ff + AW'(1) : addr_ff + crle_pkg::ROW_STEP;
         end
         // following dash or fill row
         crle_pkg::ST_NEXT: begin
            if (act == crle_pkg::ACT_DASH_H || act == crle_pkg::ACT_DASH_V) begin
               sp_a_in = pos_ff;
               sp_b_in = dash_b;
               pos_in  = pos_ff + {{(SPW - 9){1'b0}}, period};
            end else begin
               row_in    = row_ff + SPW'(1);
               sp_fix_in = row_ff + SPW'(1);
            end
         end
         crle_pkg::ST_RDWAIT: rd_in = ram_q;
         crle_pkg::ST_DONE: begin
            if (load_rsp) begin
               rsp_in.read_color = rd_ff;
               rsp_in.bad_phase  = bad_ff;
            end
         end
         default: ;
      endcase
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crle_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bg_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bg_ff        <= bg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_ff      <= rsp_in;
      rd_ff       <= rd_in;
      bad_ff      <= bad_in;
      pos_ff      <= pos_in;
      end_ff      <= end_in;
      row_ff      <= row_in;
      sp_fix_ff   <= sp_fix_in;
      sp_a_ff     <= sp_a_in;
      sp_b_ff     <= sp_b_in;
      sp_horiz_ff <= sp_horiz_in;
      cur_ff      <= cur_in;
      hi_ff       <= hi_in;
      fix_ff      <= fix_in;
      addr_ff     <= addr_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_write_in_run: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == crle_pkg::ST_RUN && act != crle_pkg::ACT_READ)
      else $error("frame write outside a span walk");

   a_cur_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == crle_pkg::ST_RUN |-> cur_ff <= hi_ff)
      else $error("span walker passed its end");

   a_rdwait_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == crle_pkg::ST_RDWAIT |=> state_ff == crle_pkg::ST_DONE)
      else $error("pixel read did not finish");

   a_bad_no_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_phase |-> rsp_data.read_color == '0)
      else $error("rejected dash carries a color");

endmodule

`default_nettype wire

FILE: dv/clipped_line_and_fill_raster_engine_core_test.sv
// self-checking testbench for the clipped line and fill raster engine core
`default_nettype none

module clipped_line_and_fill_raster_engine_core_test;

   localparam int LIMIT_CYCLES = 6000000;
   localparam int HOLD_LEN     = 3000;
   localparam int SW           = crle_pkg::SCREEN_W;
   localparam int SH           = crle_pkg::SCREEN_H;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   crle_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   crle_pkg::rsp_type rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [7:0]        csr_wr_data = '0;

   clipped_line_and_fill_raster_engine_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // shadow frame store and background register
   logic [7:0] pix_mirror [SW*SH];
   logic [7:0] bg_mirror = '0;

   crle_pkg::req_type cmd_q [$];
   crle_pkg::rsp_type rsp_expect_q [$];
   int      plotted_x [$];
   int      plotted_y [$];
   int      errors = 0;
   int      cmds_taken = 0;
   int      rsps_seen = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   bit      send_hold = 1'b0;
   int      hold_asked = 0;
   int      hold_seen = 0;
   int      hold_left = 0;
   int      n_dash = 0, n_fill = 0, n_read = 0, n_bad = 0;

   // ---------------- shadow drawing ----------------
   function automatic int clip(int v, int lim);
      if (v < 0) return 0;
      if (v >= lim) return lim - 1;
      return v;
   endfunction

   task automatic row_paint(int y, int a, int b, logic [7:0] c);
      int t;
      if (y < 0 || y >= SH) return;
      a = clip(a, SW);
      b = clip(b, SW);
      if (a > b) begin t = a; a = b; b = t; end
      for (int x = a; x <= b; x++) pix_mirror[y*SW + x] = c;
   endtask

   task automatic col_paint(int x, int a, int b, logic [7:0] c);
      int t;
      if (x < 0 || x >= SW) return;
      a = clip(a, SH);
      b = clip(b, SH);
      if (a > b) begin t = a; a = b; b = t; end
      for (int y = a; y <= b; y++) pix_mirror[y*SW + x] = c;
   endtask

   task automatic seg_paint(bit horiz, int fixed, int a, int b, logic [7:0] c);
      if (horiz) row_paint(fixed, a, b, c);
      else col_paint(fixed, a, b, c);
   endtask

   task automatic dash_paint(bit horiz, int fixed, int start, int stop, int on, int off,
                             int phase, logic [7:0] c, output bit rejected);
      int period;
      int pos;
      period = on + off;
      pos = start;
      rejected = 1'b0;
      if (phase >= period) begin
         rejected = 1'b1;
         return;
      end
      if (on == 0) return;
      if (phase != 0) begin
         pos += period - phase;
         if (phase < on) seg_paint(horiz, fixed, start, start + on - phase - 1, c);
      end
      while (pos < stop) begin
         seg_paint(horiz, fixed, pos, pos + on - 1, c);
         pos += period;
      end
   endtask

   // apply one command to the shadow store and give the expected response
   task automatic raster_predict(input crle_pkg::req_type r, output crle_pkg::rsp_type p);
      int xa, ya, xb, yb;
      bit rej;
      xa = r.x_a; ya = r.y_a; xb = r.x_b; yb = r.y_b;
      p = '0;
      rej = 1'b0;
      case (r.action)
         crle_pkg::ACT_POINT: begin
            if (xa >= 0 && xa < SW && ya >= 0 && ya < SH)
               pix_mirror[ya*SW + xa] = r.color;
         end
         crle_pkg::ACT_HLINE: row_paint(ya, xa, xb, r.color);
         crle_pkg::ACT_VLINE: col_paint(xa, ya, yb, r.color);
         crle_pkg::ACT_DASH_H: dash_paint(1'b1, ya, xa, xb, r.dash_on, r.dash_off,
                                          r.dash_phase, r.color, rej);
         crle_pkg::ACT_DASH_V: dash_paint(1'b0, xa, ya, yb, r.dash_on, r.dash_off,
                                          r.dash_phase, r.color, rej);
         crle_pkg::ACT_FILL: begin
            if (r.extent_w != 0 && r.extent_h != 0)
               for (int y = ya; y <= ya + int'(r.extent_h); y++)
                  row_paint(y, xa, xa + int'(r.extent_w), r.color);
         end
         crle_pkg::ACT_READ: begin
            if (xa >= 0 && xa < SW && ya >= 0 && ya < SH)
               p.read_color = pix_mirror[ya*SW + xa];
            else
               p.read_color = bg_mirror;
         end
         default: ;
      endcase
      p.bad_phase = rej;
   endtask

   // ---------------- command generation ----------------
   function automatic logic [11:0] pick_coord(int lim);
      int k;
      k = $urandom_range(99);
      if (k < 70) return 12'($urandom_range(lim - 1));
      if (k < 90) return 12'(int'($urandom_range(lim + 16)) - 8);
      return 12'($urandom);
   endfunction

   task automatic queue_cmd(crle_pkg::req_type r);
      if (r.action == crle_pkg::ACT_POINT) begin
         if (int'(r.x_a) >= 0 && int'(r.x_a) < SW &&
             int'(r.y_a) >= 0 && int'(r.y_a) < SH) begin
            plotted_x.push_back(r.x_a);
            plotted_y.push_back(r.y_a);
         end
      end
      cmd_q.push_back(r);
   endtask

   task automatic queue_random;
      crle_pkg::req_type r;
      int k, i;
      r = '0;
      r.color    = 8'($urandom);
      r.x_a      = pick_coord(SW);
      r.y_a      = pick_coord(SH);
      r.x_b      = pick_coord(SW);
      r.y_b      = pick_coord(SH);
      r.dash_on  = 8'($urandom_range(1, 40));
      r.dash_off = 8'($urandom_range(0, 40));
      k = $urandom_range(99);
      if (k < 10) begin
         r.dash_on  = 8'($urandom);
         r.dash_off = 8'($urandom);
      end
      r.dash_phase = 9'($urandom_range(int'(r.dash_on) + int'(r.dash_off)));
      if ($urandom_range(99) < 12) r.dash_phase = 9'($urandom);
      r.extent_w = 11'($urandom_range(0, 24));
      r.extent_h = 11'($urandom_range(0, 12));
      if ($urandom_range(99) < 2) begin
         r.extent_w = 11'($urandom);
         r.extent_h = 11'($urandom);
      end
      k = $urandom_range(99);
      if (k < 22)      r.action = crle_pkg::ACT_POINT;
      else if (k < 34) r.action = crle_pkg::ACT_HLINE;
      else if (k < 46) r.action = crle_pkg::ACT_VLINE;
      else if (k < 56) r.action = crle_pkg::ACT_DASH_H;
      else if (k < 66) r.action = crle_pkg::ACT_DASH_V;
      else if (k < 74) r.action = crle_pkg::ACT_FILL;
      else begin
         r.action = crle_pkg::ACT_READ;
         // on-screen reads only hit pixels already plotted
         if (plotted_x.size() > 0 && $urandom_range(99) < 85) begin
            i = $urandom_range(plotted_x.size() - 1);
            r.x_a = 12'(plotted_x[i]);
            r.y_a = 12'(plotted_y[i]);
         end else begin
            r.x_a = ($urandom_range(1)) ? 12'(-1 - int'($urandom_range(2047)))
                                        : 12'($urandom_range(SW, 2047));
         end
      end
      queue_cmd(r);
   endtask

   function automatic crle_pkg::req_type mk(crle_pkg::action_type a, int xa, int ya,
                                            int xb, int yb, int w, int h, int on,
                                            int off, int ph, int c);
      crle_pkg::req_type r;
      r.action = a; r.color = 8'(c);
      r.x_a = 12'(xa); r.y_a = 12'(ya); r.x_b = 12'(xb); r.y_b = 12'(yb);
      r.extent_w = 11'(w); r.extent_h = 11'(h);
      r.dash_on = 8'(on); r.dash_off = 8'(off); r.dash_phase = 9'(ph);
      return r;
   endfunction

   task automatic queue_directed;
      queue_cmd(mk(crle_pkg::ACT_POINT, 0, 0, 0, 0, 0, 0, 1, 0, 0, 8'hff));
      queue_cmd(mk(crle_pkg::ACT_POINT, SW-1, SH-1, 0, 0, 0, 0, 1, 0, 0, 8'h00));
      queue_cmd(mk(crle_pkg::ACT_POINT, -1, 5, 0, 0, 0, 0, 1, 0, 0, 8'h55));
      queue_cmd(mk(crle_pkg::ACT_POINT, 5, SH, 0, 0, 0, 0, 1, 0, 0, 8'haa));
      queue_cmd(mk(crle_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_cmd(mk(crle_pkg::ACT_READ, SW-1, SH-1, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_cmd(mk(crle_pkg::ACT_READ, -2048, 2047, 0, 0, 0, 0, 0, 0, 0, 0));
      // lines clamped and reversed, and lines with their fixed coordinate off screen
      queue_cmd(mk(crle_pkg::ACT_HLINE, 2047, 0, -2048, 0, 0, 0, 0, 0, 0, 8'h12));
      queue_cmd(mk(crle_pkg::ACT_VLINE, 0, -2048, 2047, 2047, 0, 0, 0, 0, 0, 8'h34));
      queue_cmd(mk(crle_pkg::ACT_HLINE, 0, -1, 100, 0, 0, 0, 0, 0, 0, 8'h77));
      queue_cmd(mk(crle_pkg::ACT_VLINE, SW, 0, 0, 100, 0, 0, 0, 0, 0, 8'h77));
      // dashed: bad phase, zero period, zero dash, opening dash, phase past the dash, reversed
      queue_cmd(mk(crle_pkg::ACT_DASH_H, 0, 10, 300, 0, 0, 0, 5, 3, 8, 8'h21));
      queue_cmd(mk(crle_pkg::ACT_DASH_V, 10, 0, 0, 200, 0, 0, 0, 0, 0, 8'h22));
      queue_cmd(mk(crle_pkg::ACT_DASH_V, 20, 0, 0, 230, 0, 0, 0, 7, 3, 8'h23));
      queue_cmd(mk(crle_pkg::ACT_DASH_H, 5, 20, 310, 0, 0, 0, 6, 4, 2, 8'h24));
      queue_cmd(mk(crle_pkg::ACT_DASH_V, 30, 3, 0, 230, 0, 0, 6, 4, 8, 8'h25));
      queue_cmd(mk(crle_pkg::ACT_DASH_H, 200, 30, 10, 0, 0, 0, 9, 2, 4, 8'h26));
      queue_cmd(mk(crle_pkg::ACT_DASH_H, -40, 40, 400, 0, 0, 0, 255, 255, 511, 8'h27));
      queue_cmd(mk(crle_pkg::ACT_DASH_V, 40, -30, 0, 300, 0, 0, 255, 0, 0, 8'h28));
      // fills: empty width, empty height, clipped, and the widest
      queue_cmd(mk(crle_pkg::ACT_FILL, 10, 10, 0, 0, 0, 5, 0, 0, 0, 8'h31));
      queue_cmd(mk(crle_pkg::ACT_FILL, 10, 10, 0, 0, 5, 0, 0, 0, 0, 8'h32));
      queue_cmd(mk(crle_pkg::ACT_FILL, -5, -3, 0, 0, 12, 9, 0, 0, 0, 8'h33));
      queue_cmd(mk(crle_pkg::ACT_FILL, -2048, -2048, 0, 0, 2047, 2047, 0, 0, 0, 8'h35));
      queue_cmd(mk(crle_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // ---------------- driver ----------------
   // predicts each command at its transfer, then offers the next one
   always @(posedge clock) begin
      crle_pkg::rsp_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            raster_predict(req_data, p);
            rsp_expect_q.push_back(p);
            cmds_taken++;
            case (req_data.action)
               crle_pkg::ACT_DASH_H, crle_pkg::ACT_DASH_V: n_dash++;
               crle_pkg::ACT_FILL: n_fill++;
               crle_pkg::ACT_READ: n_read++;
               default: ;
            endcase
            if (p.bad_phase) n_bad++;
         end
         if (!req_valid || !req_stall) begin
            if (cmd_q.size() > 0 && !send_hold &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= cmd_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- receiver stall ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_LEN;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      crle_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsps_seen++;
         if (rsp_expect_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response read_color=%0h bad_phase=%0b",
                     $time, rsp_data.read_color, rsp_data.bad_phase);
         end else begin
            e = rsp_expect_q.pop_front();
            if (rsp_data.read_color !== e.read_color) begin
               errors++;
               $display("%0t: read_color expected %0h actual %0h",
                        $time, e.read_color, rsp_data.read_color);
            end
            if (rsp_data.bad_phase !== e.bad_phase) begin
               errors++;
               $display("%0t: bad_phase expected %0b actual %0b",
                        $time, e.bad_phase, rsp_data.bad_phase);
            end
         end
      end
   end

   // ---------------- timeout ----------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("clipped_line_and_fill_raster_engine_core verification failed");
         $finish;
      end
   end

   // ---------------- sequence ----------------
   task automatic drain;
      while (cmd_q.size() > 0 || req_valid || rsp_expect_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_bg(logic [7:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      bg_mirror = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int idle_set [4];
      int stall_set [4];
      logic [7:0] bg_set [4];
      idle_set  = '{0, 59, 0, 26};
      stall_set = '{0, 0, 59, 26};
      bg_set    = '{8'hff, 8'h00, 8'ha5, 8'h5a};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed pass with the background at reset value
      queue_directed();
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_bg(bg_set[ph]);
         if (ph == 3) write_bg(8'($urandom));
         send_idle_pct = idle_set[ph];
         stall_pct     = stall_set[ph];
         queue_cmd(mk(crle_pkg::ACT_READ, 400, -7, 0, 0, 0, 0, 0, 0, 0, 0));
         for (int i = 0; i < 156; i++) queue_random();
         if (ph == 0) begin
            // long receiver hold while commands keep coming
            repeat (10) @(posedge clock);
            hold_asked++;
         end
         if (ph == 2) begin
            // sender pause until every response has come back
            while (cmd_q.size() > 80) @(posedge clock);
            send_hold = 1'b1;
            while (req_valid || rsp_expect_q.size() > 0) @(posedge clock);
            send_hold = 1'b0;
         end
         drain();
      end

      repeat (400) @(posedge clock);
      $display("covered %0d commands (%0d dashed, %0d fills, %0d reads, %0d bad phase)",
               cmds_taken, n_dash, n_fill, n_read, n_bad);
      $display("%0d responses checked over four backpressure phases", rsps_seen);
      if (errors == 0 && rsp_expect_q.size() == 0) begin
         $display("clipped_line_and_fill_raster_engine_core verification clean");
      end else begin
         $display("clipped_line_and_fill_raster_engine_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: clipped_line_and_fill_raster_engine_core.f
rtl/core/crle_pkg.sv
rtl/core/crle_ram.sv
rtl/core/clipped_line_and_fill_raster_engine_core.sv
dv/clipped_line_and_fill_raster_engine_core_test.sv
